>>> rtl/vrcbm_pkg.sv
// Shared types and constants for the VRC bank mapper register decoder.
package vrcbm_pkg;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_PRG    = 2'd1,
    ACT_CHR    = 2'd2,
    ACT_MIRROR = 2'd3
  } action_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
  } in_beat_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] dest_base;
    logic [18:0] rom_offset;
    logic        mirror_mode;
    logic        swap_mode;
  } out_beat_t;

  // Register addresses
  localparam logic [15:0] ADDR_MIRROR0 = 16'h9000;
  localparam logic [15:0] ADDR_MIRROR1 = 16'h9002;
  localparam logic [15:0] ADDR_SWAP0   = 16'h9004;
  localparam logic [15:0] ADDR_SWAP1   = 16'h9006;
  localparam logic [15:0] ADDR_PRG0    = 16'h8000;
  localparam logic [15:0] ADDR_PRG1    = 16'hA000;
  localparam logic [15:0] GROUP_MASK   = 16'hFFF9;
  localparam logic [15:0] CHR_MASK     = 16'h0FF9;
  localparam logic [3:0]  CHR_HI_FIRST = 4'hB;
  localparam logic [3:0]  CHR_HI_LAST  = 4'hE;

  // CPU windows
  localparam logic [15:0] WIN_8000 = 16'h8000;
  localparam logic [15:0] WIN_A000 = 16'hA000;
  localparam logic [15:0] WIN_C000 = 16'hC000;

  localparam int CHR_BANK_BYTES = 1024;
  localparam int PRG_BANK_BYTES = 8192;
  localparam int CHR_SHIFT      = $clog2(CHR_BANK_BYTES);
  localparam int PRG_SHIFT      = $clog2(PRG_BANK_BYTES);
  localparam int CHR_SLOTS      = 8;

endpackage

>>> rtl/vrc_bank_mapper_regs_top.sv
// VRC bank mapper register decoder: one result beat (bank-load, mirroring or no-op command) per CPU register write.
//
//   channel | ports                         | beat
//   --------+-------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_beat   | addr, data (one CPU write)
//   output  | out_valid, out_ready, out_beat| action, dest_base, rom_offset,
//           |                               | mirror_mode, swap_mode
//
// One beat per cycle sustained while out_ready is high; an accepted beat is held in the
// input register and then decoded into the result register, which drives
// out_valid and out_beat.
// Mapper state (swap, mirroring, CHR low nibbles) updates as a beat moves to
// the result register, so results stay in write order.
// rst_n is synchronous, active low; it clears the mapper state and both valid flags.
// A stalled result holds; the input register still takes one more beat.
module vrc_bank_mapper_regs_top
  import vrcbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      in_valid_r;
  in_beat_t  in_beat_r;
  logic      out_valid_r;
  out_beat_t out_beat_r;
  logic      prg_swap_r;
  logic      mirror_r;
  logic [3:0] nib_r [CHR_SLOTS];

  logic      advance;
  out_beat_t res_nxt;
  logic      prg_swap_nxt;
  logic      mirror_nxt;
  logic      nib_we;
  logic [2:0] slot;
  logic [3:0] hi;
  logic [3:0] hi_off;
  logic       chr_hit;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign hi      = in_beat_r.addr[15:12];
  assign hi_off  = hi - CHR_HI_FIRST;
  assign slot    = {hi_off[1:0], in_beat_r.addr[2]};
  assign chr_hit = (hi >= CHR_HI_FIRST) && (hi <= CHR_HI_LAST) &&
                   ((in_beat_r.addr & CHR_MASK) == 16'h0000);

  always_comb begin
    res_nxt            = '0;
    res_nxt.action     = ACT_NONE;
    prg_swap_nxt       = prg_swap_r;
    mirror_nxt         = mirror_r;
    nib_we             = 1'b0;
    if (in_beat_r.addr == ADDR_SWAP0 || in_beat_r.addr == ADDR_SWAP1) begin
      prg_swap_nxt = in_beat_r.data[0];
    end else if (in_beat_r.addr == ADDR_MIRROR0 || in_beat_r.addr == ADDR_MIRROR1) begin
      mirror_nxt     = ~in_beat_r.data[0];
      res_nxt.action = ACT_MIRROR;
    end else if ((in_beat_r.addr & GROUP_MASK) == ADDR_PRG0) begin
      res_nxt.action     = ACT_PRG;
      res_nxt.dest_base  = prg_swap_r ? WIN_C000 : WIN_8000;
      res_nxt.rom_offset = 19'(in_beat_r.data[4:0]) << PRG_SHIFT;
    end else if ((in_beat_r.addr & GROUP_MASK) == ADDR_PRG1) begin
      res_nxt.action     = ACT_PRG;
      res_nxt.dest_base  = WIN_A000;
      res_nxt.rom_offset = 19'(in_beat_r.data[4:0]) << PRG_SHIFT;
    end else if (chr_hit) begin
      // +0/+4 store the low nibble, +2/+6 complete the bank and load
      if (!in_beat_r.addr[1]) begin
        nib_we = 1'b1;
      end else begin
        res_nxt.action     = ACT_CHR;
        res_nxt.dest_base  = 16'(slot) << CHR_SHIFT;
        res_nxt.rom_offset = 19'({in_beat_r.data[4:0], nib_r[slot]}) << CHR_SHIFT;
      end
    end
    res_nxt.mirror_mode = mirror_nxt;
    res_nxt.swap_mode   = prg_swap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prg_swap_r  <= 1'b0;
      mirror_r    <= 1'b0;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        nib_r[i] <= 4'h0;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        prg_swap_r  <= prg_swap_nxt;
        mirror_r    <= mirror_nxt;
        if (nib_we) begin
          nib_r[slot] <= in_beat_r.data[3:0];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_beat_r <= in_beat;
    end
    if (advance) begin
      out_beat_r <= res_nxt;
    end
  end

endmodule

>>> rtl/vrcbm_checker.sv
// Port-level checks for the VRC bank mapper register decoder, bound to the top level.
module vrcbm_checker
  import vrcbm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not empty right after reset");

  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.action == ACT_NONE || out_beat.action == ACT_MIRROR)
    |-> out_beat.dest_base == 16'h0000 && out_beat.rom_offset == 19'h00000)
    else $error("payload on a command without one");

  a_prg_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.action == ACT_PRG
    |-> out_beat.rom_offset[PRG_SHIFT-1:0] == '0 &&
        (out_beat.dest_base == WIN_A000 ||
         (out_beat.dest_base == WIN_C000 && out_beat.swap_mode) ||
         (out_beat.dest_base == WIN_8000 && !out_beat.swap_mode)))
    else $error("PRG load window disagrees with swap mode");

  a_chr_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.action == ACT_CHR
    |-> out_beat.dest_base[CHR_SHIFT-1:0] == '0 && out_beat.dest_base[15:13] == 3'd0 &&
        out_beat.rom_offset[CHR_SHIFT-1:0] == '0)
    else $error("CHR load not slot aligned");

endmodule

bind vrc_bank_mapper_regs_top vrcbm_checker u_vrcbm_checker (.*);
